@@ rtl/sld_pkg.sv @@
// Package for the suspension linkage deflection block: constants, types and tables.
package sld_pkg;

  localparam int CoordW = 19;
  localparam int LinkW = 18;
  localparam int AngW = 16;
  localparam int IntvW = 16;
  localparam int DeflW = 20;
  localparam int SpeedW = 32;
  localparam int ZW = 34;
  localparam int CsW = 32;
  localparam int AtanEntries = 24;
  localparam int CordicStepsDefault = 16;

  localparam logic signed [ZW-1:0] PiQ28 = 34'sd843314857;
  localparam logic signed [ZW-1:0] HalfPiQ28 = 34'sd421657428;
  localparam logic signed [ZW-1:0] TwoPiQ28 = 34'sd1686629713;
  localparam logic signed [CsW-1:0] GainQ30 = 32'sd652032874;
  localparam logic [DeflW-1:0] LenMax = 20'hFFFFF;

  localparam logic [2:0] RegLowerX = 3'd0;
  localparam logic [2:0] RegLowerY = 3'd1;
  localparam logic [2:0] RegPivotX = 3'd2;
  localparam logic [2:0] RegPivotY = 3'd3;
  localparam logic [2:0] RegAxisX = 3'd4;
  localparam logic [2:0] RegAxisY = 3'd5;
  localparam logic [2:0] RegLink = 3'd6;

  typedef struct packed {
    logic start_arm;
    logic start_link;
    logic start_lin;
    logic start_sqrt;
    logic start_div_d;
    logic start_div_l;
    logic capture;
    logic commit;
  } sld_cmd_t;

  typedef struct packed {
    logic cordic_done;
    logic sqrt_done;
    logic div_done;
  } sld_stat_t;

  function automatic logic signed [ZW-1:0] atan_q28(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    begin
      case (i)
        5'd0: v = 34'sd210828714;
        5'd1: v = 34'sd124459457;
        5'd2: v = 34'sd65760959;
        5'd3: v = 34'sd33381290;
        5'd4: v = 34'sd16755422;
        5'd5: v = 34'sd8385879;
        5'd6: v = 34'sd4193963;
        5'd7: v = 34'sd2097109;
        5'd8: v = 34'sd1048571;
        5'd9: v = 34'sd524287;
        default: v = (i < 5'd24) ? (34'sd1 <<< (5'd28 - i)) : 34'sd0;
      endcase
      return v;
    end
  endfunction

endpackage

@@ rtl/sld_if.sv @@
// Valid/ready channel interface carrying a payload of a given type.
interface sld_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/suspension_linkage_deflection.sv @@
// Top level of the suspension linkage deflection block.
// Each item is first loaded into the item registers, then runs through a CORDIC pass for
// the arm angle and one for the link angle (each followed by the rotation products), a square
// root of the squared mount distance, and for an update a third CORDIC pass for the linear
// deflection and, unless the interval is zero, two divisions for the speeds, all on the
// shared iterative units. One item is worked on at a time; the result is held in the output
// register until taken, and the next item is accepted once it has gone.
module suspension_linkage_deflection import sld_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDefault
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_cmd,
  input  logic signed [AngW-1:0] in_arm_angle,
  input  logic signed [AngW-1:0] in_link_angle,
  input  logic [IntvW-1:0] in_interval_ms,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [DeflW-1:0] out_deflection,
  output logic signed [SpeedW-1:0] out_deflection_speed,
  output logic signed [CoordW-1:0] out_linear_deflection,
  output logic signed [SpeedW-1:0] out_linear_speed,
  output logic out_zero_interval,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [CoordW-1:0] cfg_data
);
  // Configuration registers, writable at any time the block is idle.
  logic signed [CoordW-1:0] lx_r, ly_r, px_r, py_r, ax_r, ay_r;
  logic [LinkW-1:0] link_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lx_r <= 19'sd145532;
      ly_r <= 19'sd31960;
      px_r <= -19'sd88022;
      py_r <= 19'sd139206;
      ax_r <= -19'sd97109;
      ay_r <= 19'sd143379;
      link_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegLowerX: lx_r <= cfg_data;
        RegLowerY: ly_r <= cfg_data;
        RegPivotX: px_r <= cfg_data;
        RegPivotY: py_r <= cfg_data;
        RegAxisX: ax_r <= cfg_data;
        RegAxisY: ay_r <= cfg_data;
        RegLink: link_r <= cfg_data[LinkW-1:0];
        default: ;
      endcase
    end
  end

  // The input item is held for the whole computation.
  logic signed [AngW-1:0] arm_r, link_ang_r;
  logic [IntvW-1:0] intv_r;
  logic busy, in_fire;
  assign in_ready = !busy;
  assign in_fire = in_valid && in_ready;
  always_ff @(posedge clk) begin
    if (in_fire) begin
      arm_r <= in_arm_angle;
      link_ang_r <= in_link_angle;
      intv_r <= in_interval_ms;
    end
  end

  sld_cmd_t  dcmd;
  sld_stat_t dstat;

  sld_ctrl u_ctrl (
    .clk, .rst_n,
    .in_fire, .in_cmd,
    .intv_zero(intv_r == '0),
    .out_free(out_ready),
    .stat(dstat),
    .cmd(dcmd),
    .busy,
    .result_valid(out_valid)
  );

  sld_datapath #(.CordicSteps(CORDIC_STEPS)) u_dp (
    .clk, .rst_n,
    .cmd(dcmd), .stat(dstat),
    .arm_angle(arm_r), .link_angle(link_ang_r), .interval_ms(intv_r),
    .lower_x(lx_r), .lower_y(ly_r), .pivot_x(px_r), .pivot_y(py_r),
    .axis_x(ax_r), .axis_y(ay_r), .link_len(link_r),
    .deflection(out_deflection), .deflection_speed(out_deflection_speed),
    .linear_deflection(out_linear_deflection), .linear_speed(out_linear_speed),
    .zero_interval(out_zero_interval)
  );
endmodule

@@ rtl/sld_datapath.sv @@
// Datapath: shared CORDIC, multiplier, square root and divider with the working registers.
module sld_datapath import sld_pkg::*; #(
  parameter int CordicSteps = CordicStepsDefault
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sld_cmd_t                 cmd,
  output sld_stat_t                stat,
  input  logic signed [AngW-1:0]   arm_angle,
  input  logic signed [AngW-1:0]   link_angle,
  input  logic [IntvW-1:0]         interval_ms,
  input  logic signed [CoordW-1:0] lower_x,
  input  logic signed [CoordW-1:0] lower_y,
  input  logic signed [CoordW-1:0] pivot_x,
  input  logic signed [CoordW-1:0] pivot_y,
  input  logic signed [CoordW-1:0] axis_x,
  input  logic signed [CoordW-1:0] axis_y,
  input  logic [LinkW-1:0]         link_len,
  output logic signed [DeflW-1:0]  deflection,
  output logic signed [SpeedW-1:0] deflection_speed,
  output logic signed [CoordW-1:0] linear_deflection,
  output logic signed [SpeedW-1:0] linear_speed,
  output logic                     zero_interval
);
  localparam int StepW = $clog2(CordicSteps + 1);
  localparam int PW = 64;

  // CORDIC
  logic signed [ZW-1:0]  z_r;
  logic signed [CsW+1:0] x_r, y_r;
  logic [StepW-1:0]      it_r;
  logic                  neg_r, crun_r, cdone_r;
  logic signed [ZW-1:0]  z0;
  logic signed [AngW-1:0] ang;
  logic                  neg0;

  always_comb begin
    ang = cmd.start_arm ? arm_angle : link_angle;
    z0 = {{(ZW-AngW-16){ang[AngW-1]}}, ang, 16'd0};
    // Q4.12 range never needs more than one turn correction.
    if (z0 > PiQ28) z0 = z0 - TwoPiQ28;
    else if (z0 <= -PiQ28) z0 = z0 + TwoPiQ28;
    neg0 = 1'b0;
    if (z0 > HalfPiQ28) begin
      z0 = z0 - PiQ28;
      neg0 = 1'b1;
    end else if (z0 < -HalfPiQ28) begin
      z0 = z0 + PiQ28;
      neg0 = 1'b1;
    end
  end

  logic cstart;
  assign cstart = cmd.start_arm | cmd.start_link | cmd.start_lin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crun_r <= 1'b0;
      cdone_r <= 1'b0;
    end else begin
      cdone_r <= 1'b0;
      if (cstart) begin
        z_r <= z0;
        x_r <= {{2{GainQ30[CsW-1]}}, GainQ30};
        y_r <= '0;
        it_r <= '0;
        neg_r <= neg0;
        crun_r <= 1'b1;
      end else if (crun_r) begin
        if (z_r >= 0) begin
          x_r <= x_r - (y_r >>> it_r);
          y_r <= y_r + (x_r >>> it_r);
          z_r <= z_r - atan_q28(5'(it_r));
        end else begin
          x_r <= x_r + (y_r >>> it_r);
          y_r <= y_r - (x_r >>> it_r);
          z_r <= z_r + atan_q28(5'(it_r));
        end
        it_r <= it_r + 1'b1;
        if (it_r == StepW'(CordicSteps - 1)) begin
          crun_r <= 1'b0;
          cdone_r <= 1'b1;
        end
      end
    end
  end

  logic signed [CsW+1:0] cos_v, sin_v;
  assign cos_v = neg_r ? -x_r : x_r;
  assign sin_v = neg_r ? -y_r : y_r;

  // Rotation: products sequenced by a small phase counter, one multiply a cycle.
  logic [2:0]            ph_r;
  logic                  mrun_r;
  logic signed [CsW+1:0] c_r, s_r;
  logic [1:0]            mode_r;  // 0 arm, 1 link, 2 linear
  logic signed [PW-1:0]  acc_r;
  logic signed [DeflW:0] lx_r, ly_r, ux_r, uy_r;
  logic signed [CoordW:0] dxp, dyp;
  logic signed [CoordW+1:0] lin_raw_r;
  logic                  mdone_r;

  assign dxp = (CoordW+1)'(axis_x) - (CoordW+1)'(pivot_x);
  assign dyp = (CoordW+1)'(axis_y) - (CoordW+1)'(pivot_y);

  logic signed [CsW+1:0] ma;
  logic signed [CoordW+1:0] mb;
  logic signed [PW-1:0]  prod, rnd;

  always_comb begin
    ma = c_r;
    mb = '0;
    unique case ({mode_r, ph_r})
      {2'd0, 3'd0}: begin ma = c_r; mb = (CoordW+2)'(lower_x); end
      {2'd0, 3'd1}: begin ma = -s_r; mb = (CoordW+2)'(lower_y); end
      {2'd0, 3'd2}: begin ma = s_r; mb = (CoordW+2)'(lower_x); end
      {2'd0, 3'd3}: begin ma = c_r; mb = (CoordW+2)'(lower_y); end
      {2'd1, 3'd0}: begin ma = c_r; mb = (CoordW+2)'(dxp); end
      {2'd1, 3'd1}: begin ma = -s_r; mb = (CoordW+2)'(dyp); end
      {2'd1, 3'd2}: begin ma = s_r; mb = (CoordW+2)'(dxp); end
      {2'd1, 3'd3}: begin ma = c_r; mb = (CoordW+2)'(dyp); end
      default: begin ma = c_r; mb = $signed({3'b000, link_len}); end
    endcase
    prod = PW'(ma) * PW'(mb);
    rnd = (acc_r + prod + (PW'(1) <<< 29)) >>> 30;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mrun_r <= 1'b0;
      mdone_r <= 1'b0;
      mode_r <= 2'd0;
    end else begin
      mdone_r <= 1'b0;
      if (cstart) mode_r <= cmd.start_arm ? 2'd0 : (cmd.start_link ? 2'd1 : 2'd2);
      if (cdone_r) begin
        c_r <= cos_v;
        s_r <= sin_v;
        ph_r <= '0;
        acc_r <= '0;
        mrun_r <= 1'b1;
      end else if (mrun_r) begin
        ph_r <= ph_r + 1'b1;
        if (ph_r[0] == 1'b0) acc_r <= prod;
        else acc_r <= '0;
        if (mode_r == 2'd2) begin
          lin_raw_r <= (CoordW+2)'(rnd);
          mrun_r <= 1'b0;
          mdone_r <= 1'b1;
        end else begin
          unique case (ph_r)
            3'd1: if (mode_r == 2'd0) lx_r <= (DeflW+1)'(rnd);
                  else ux_r <= (DeflW+1)'(rnd) + pivot_x;
            3'd3: begin
              if (mode_r == 2'd0) ly_r <= (DeflW+1)'(rnd);
              else uy_r <= (DeflW+1)'(rnd) + pivot_y;
              mrun_r <= 1'b0;
              mdone_r <= 1'b1;
            end
            default: ;
          endcase
        end
      end
    end
  end
  assign stat.cordic_done = mdone_r;

  // Square root, one result bit per cycle over the 44-bit radicand.
  localparam int RW = 44;
  logic signed [DeflW+1:0] ddx, ddy;
  logic [RW-1:0] sq_n;
  logic [RW/2:0] root_r;
  logic [5:0]    scnt_r;
  logic          srun_r, sdone_r;
  logic [DeflW-1:0] len_r;

  assign ddx = (DeflW+2)'(ux_r) - (DeflW+2)'(lx_r);
  assign ddy = (DeflW+2)'(uy_r) - (DeflW+2)'(ly_r);
  assign sq_n = RW'(ddx) * RW'(ddx) + RW'(ddy) * RW'(ddy);

  logic [RW+1:0] rr_r;  // remainder
  logic [RW-1:0] nn_r;
  logic [RW+1:0] rnx;
  logic [RW+1:0] tv;
  always_comb begin
    rnx = {rr_r[RW-1:0], nn_r[RW-1:RW-2]};
    tv = {root_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srun_r <= 1'b0;
      sdone_r <= 1'b0;
    end else begin
      sdone_r <= 1'b0;
      if (cmd.start_sqrt) begin
        nn_r <= sq_n;
        rr_r <= '0;
        root_r <= '0;
        scnt_r <= '0;
        srun_r <= 1'b1;
      end else if (srun_r) begin
        nn_r <= nn_r << 2;
        if (rnx >= tv) begin
          rr_r <= rnx - tv;
          root_r <= {root_r[RW/2-1:0], 1'b1};
        end else begin
          rr_r <= rnx;
          root_r <= {root_r[RW/2-1:0], 1'b0};
        end
        scnt_r <= scnt_r + 1'b1;
        if (scnt_r == 6'(RW/2 - 1)) begin
          srun_r <= 1'b0;
          sdone_r <= 1'b1;
        end
      end else if (sdone_r == 1'b0 && scnt_r == 6'(RW/2)) begin
        scnt_r <= '0;
      end
    end
  end
  // Round to nearest: bump when remainder exceeds root.
  logic [RW/2+1:0] len_full;
  assign len_full = (RW/2+2)'(root_r) + ((rr_r > (RW+2)'(root_r)) ? 1'b1 : 1'b0);
  assign len_r = (len_full > (RW/2+2)'(LenMax)) ? LenMax : DeflW'(len_full);
  assign stat.sqrt_done = sdone_r;

  // State and deflection values.
  logic [DeflW-1:0]        zero_r;
  logic signed [DeflW-1:0] last_d_r, defl_r;
  logic signed [CoordW-1:0] last_l_r, lin_r;
  logic signed [DeflW+1:0] dsub;
  logic signed [DeflW-1:0] defl_sat;
  logic signed [CoordW-1:0] lin_sat;

  assign dsub = $signed({2'b00, len_r}) - $signed({2'b00, zero_r});
  assign defl_sat = (dsub > 22'sd524287) ? 20'sd524287 :
                    (dsub < -22'sd524288) ? -20'sd524288 : DeflW'(dsub);
  assign lin_sat = (lin_raw_r > 21'sd262143) ? 19'sd262143 :
                   (lin_raw_r < -21'sd262144) ? -19'sd262144 : CoordW'(lin_raw_r);

  // Restoring signed divider, shared by both speeds: |num| / interval.
  localparam int NW = 31;
  logic [NW-1:0]  q_r;
  logic [IntvW:0] dr_r;
  logic [NW-1:0]  dn_r;
  logic [4:0]     dcnt_r;
  logic           drun_r, ddone_r, dneg_r;
  logic signed [NW:0] num;
  logic [NW-1:0]  num_mag;
  logic [IntvW:0] dsh;

  assign num = cmd.start_div_d ? ((NW+1)'(defl_r) - (NW+1)'(last_d_r)) * 32'sd1000
                               : ((NW+1)'(lin_r) - (NW+1)'(last_l_r)) * 32'sd1000;
  assign num_mag = num[NW] ? NW'(-num) : NW'(num);
  assign dsh = {dr_r[IntvW-1:0], dn_r[NW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drun_r <= 1'b0;
      ddone_r <= 1'b0;
    end else begin
      ddone_r <= 1'b0;
      if (cmd.start_div_d || cmd.start_div_l) begin
        dn_r <= num_mag;
        dneg_r <= num[NW];
        dr_r <= '0;
        q_r <= '0;
        dcnt_r <= '0;
        drun_r <= 1'b1;
      end else if (drun_r) begin
        dn_r <= dn_r << 1;
        if (dsh >= {1'b0, interval_ms}) begin
          dr_r <= dsh - {1'b0, interval_ms};
          q_r <= {q_r[NW-2:0], 1'b1};
        end else begin
          dr_r <= dsh;
          q_r <= {q_r[NW-2:0], 1'b0};
        end
        dcnt_r <= dcnt_r + 1'b1;
        if (dcnt_r == 5'(NW - 1)) begin
          drun_r <= 1'b0;
          ddone_r <= 1'b1;
        end
      end
    end
  end
  assign stat.div_done = ddone_r;

  logic signed [SpeedW-1:0] quo;
  assign quo = dneg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

  logic spd_sel_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_r <= '0;
      last_d_r <= '0;
      last_l_r <= '0;
      spd_sel_r <= 1'b0;
    end else begin
      if (cmd.start_sqrt) spd_sel_r <= 1'b0;
      if (sdone_r) defl_r <= defl_sat;
      // A capture reports zeros, so it takes priority over the fresh deflection.
      if (cmd.capture) begin
        zero_r <= len_r;
        defl_r <= '0;
        lin_r <= '0;
        deflection_speed <= '0;
        linear_speed <= '0;
        zero_interval <= 1'b0;
      end
      if (mdone_r && mode_r == 2'd2) begin
        lin_r <= lin_sat;
        deflection_speed <= '0;
        linear_speed <= '0;
        zero_interval <= (interval_ms == '0);
      end
      if (ddone_r) begin
        if (!spd_sel_r) deflection_speed <= quo;
        else linear_speed <= quo;
        spd_sel_r <= ~spd_sel_r;
      end
      if (cmd.commit) begin
        last_d_r <= defl_r;
        last_l_r <= lin_r;
      end
    end
  end
  assign deflection = defl_r;
  assign linear_deflection = lin_r;
endmodule

@@ rtl/sld_ctrl.sv @@
// Sequencing controller for the linkage deflection datapath.
module sld_ctrl import sld_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  logic      in_cmd,
  input  logic      intv_zero,
  input  logic      out_free,
  input  sld_stat_t stat,
  output sld_cmd_t  cmd,
  output logic      busy,
  output logic      result_valid
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ARM = 4'd1;
  localparam logic [3:0] S_LINK = 4'd2;
  localparam logic [3:0] S_SQRT = 4'd3;
  localparam logic [3:0] S_LIN = 4'd4;
  localparam logic [3:0] S_DIVD = 4'd5;
  localparam logic [3:0] S_DIVL = 4'd6;
  localparam logic [3:0] S_DONE = 4'd7;
  localparam logic [3:0] S_OUT = 4'd8;
  localparam logic [3:0] S_WAITD = 4'd9;
  localparam logic [3:0] S_LOAD = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       cmd_r, cmd_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: if (in_fire) begin
        cmd_nxt = in_cmd;
        state_nxt = S_LOAD;
      end
      // The item registers hold the new angles from here on.
      S_LOAD: begin
        cmd.start_arm = 1'b1;
        state_nxt = S_ARM;
      end
      S_ARM: if (stat.cordic_done) begin
        cmd.start_link = 1'b1;
        state_nxt = S_LINK;
      end
      S_LINK: if (stat.cordic_done) begin
        cmd.start_sqrt = 1'b1;
        state_nxt = S_SQRT;
      end
      S_SQRT: if (stat.sqrt_done) begin
        if (!cmd_r) begin
          cmd.capture = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.start_lin = 1'b1;
          state_nxt = S_LIN;
        end
      end
      S_LIN: if (stat.cordic_done) begin
        state_nxt = intv_zero ? S_DONE : S_DIVD;
      end
      S_DIVD: begin
        cmd.start_div_d = 1'b1;
        state_nxt = S_WAITD;
      end
      S_WAITD: if (stat.div_done) begin
        cmd.start_div_l = 1'b1;
        state_nxt = S_DIVL;
      end
      S_DIVL: if (stat.div_done) state_nxt = S_DONE;
      S_DONE: begin
        cmd.commit = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cmd_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cmd_r <= cmd_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign result_valid = (state_r == S_OUT);

  a_one_start: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.start_arm, cmd.start_link, cmd.start_lin}) <= 1)
    else $error("two CORDIC starts at once");
  a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_arm |-> state_r == S_LOAD)
    else $error("arm start outside load");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !out_free) |=> state_r == S_OUT)
    else $error("result dropped");
endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the suspension linkage deflection block.
module tb;
  import sld_pkg::*;

  localparam int Steps = CordicStepsDefault;
  localparam int WatchdogLimit = 6000;
  localparam int SettleCycles = 250;
  localparam int RandomPerPhase = 240;

  typedef struct packed {
    logic                   cmd;
    logic signed [AngW-1:0] arm_angle;
    logic signed [AngW-1:0] link_angle;
    logic [IntvW-1:0]       interval_ms;
  } angle_item_t;

  typedef struct packed {
    logic signed [DeflW-1:0]  deflection;
    logic signed [SpeedW-1:0] deflection_speed;
    logic signed [CoordW-1:0] linear_deflection;
    logic signed [SpeedW-1:0] linear_speed;
    logic                     zero_interval;
  } deflection_t;

  typedef struct packed {
    logic [2:0]        index;
    logic [CoordW-1:0] data;
  } reg_write_t;

  // Predicts the damper deflection for each accepted item and holds what is owed.
  class deflection_board;
    longint mount[6];
    longint link_len;
    longint zero_len;
    longint prev_defl;
    longint prev_lin;
    deflection_t owed[$];
    int errors;
    int checked;

    function new();
      mount[0] = 145532;
      mount[1] = 31960;
      mount[2] = -88022;
      mount[3] = 139206;
      mount[4] = -97109;
      mount[5] = 143379;
      link_len = 0;
      zero_len = 0;
      prev_defl = 0;
      prev_lin = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [2:0] index, logic [CoordW-1:0] data);
      if (index <= RegAxisY) mount[index] = longint'($signed(data));
      else if (index == RegLink) link_len = longint'(data[LinkW-1:0]);
    endfunction

    function longint round_q30(longint v);
      return (v + (longint'(1) << 29)) >>> 30;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void sincos(longint ang, output longint c, output longint s);
      longint z, x, y, nx;
      bit flip;
      z = ang * 65536;
      x = longint'(GainQ30);
      y = 0;
      flip = 0;
      for (int i = 0; i < 2 && z > longint'(PiQ28); i++) z -= longint'(TwoPiQ28);
      for (int i = 0; i < 2 && z <= -longint'(PiQ28); i++) z += longint'(TwoPiQ28);
      if (z > longint'(HalfPiQ28)) begin
        z -= longint'(PiQ28);
        flip = 1;
      end else if (z < -longint'(HalfPiQ28)) begin
        z += longint'(PiQ28);
        flip = 1;
      end
      for (int i = 0; i < Steps && i < AtanEntries; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z -= longint'(atan_q28(i[4:0]));
        end else begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z += longint'(atan_q28(i[4:0]));
        end
        x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function longint root_nearest(longint unsigned n);
      longint unsigned rem, r, b;
      rem = n;
      r = 0;
      b = longint'(1) << 62;
      while (b > rem) b >>= 2;
      while (b != 0) begin
        if (rem >= r + b) begin
          rem -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      if (rem > r) r++;
      return longint'(r);
    endfunction

    function longint damper_len(longint arm, longint link);
      longint c, s, lx, ly, ux, uy, dx, dy, len;
      sincos(arm, c, s);
      lx = round_q30(c * mount[0] - s * mount[1]);
      ly = round_q30(s * mount[0] + c * mount[1]);
      sincos(link, c, s);
      dx = mount[4] - mount[2];
      dy = mount[5] - mount[3];
      ux = mount[2] + round_q30(c * dx - s * dy);
      uy = mount[3] + round_q30(s * dx + c * dy);
      dx = ux - lx;
      dy = uy - ly;
      len = root_nearest(longint'(dx * dx) + longint'(dy * dy));
      return len > longint'(LenMax) ? longint'(LenMax) : len;
    endfunction

    function longint rate(longint now, longint was, longint intv);
      return clip((now - was) * 1000 / intv, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function void note_input(angle_item_t it);
      longint len, defl, lin, c, s, intv;
      deflection_t r;
      len = damper_len(longint'(it.arm_angle), longint'(it.link_angle));
      r = '0;
      if (!it.cmd) begin
        zero_len = len;
      end else begin
        intv = longint'(it.interval_ms);
        defl = clip(len - zero_len, -524288, 524287);
        sincos(longint'(it.link_angle), c, s);
        lin = clip(round_q30(link_len * c), -262144, 262143);
        r.deflection = defl[DeflW-1:0];
        r.linear_deflection = lin[CoordW-1:0];
        if (intv == 0) begin
          r.zero_interval = 1'b1;
        end else begin
          r.deflection_speed = SpeedW'(rate(defl, prev_defl, intv));
          r.linear_speed = SpeedW'(rate(lin, prev_lin, intv));
        end
        prev_defl = defl;
        prev_lin = lin;
      end
      owed.push_back(r);
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("mismatch on result %0d: %s got %0d, expected %0d", checked, what, got, want);
    endtask

    task check_result(deflection_t got);
      deflection_t want;
      if (owed.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        want = owed.pop_front();
        if (got.deflection !== want.deflection)
          report("deflection", got.deflection, want.deflection);
        if (got.deflection_speed !== want.deflection_speed)
          report("deflection_speed", got.deflection_speed, want.deflection_speed);
        if (got.linear_deflection !== want.linear_deflection)
          report("linear_deflection", got.linear_deflection, want.linear_deflection);
        if (got.linear_speed !== want.linear_speed)
          report("linear_speed", got.linear_speed, want.linear_speed);
        if (got.zero_interval !== want.zero_interval)
          report("zero_interval", got.zero_interval, want.zero_interval);
      end
      checked++;
    endtask
  endclass

  logic clk;
  logic rst_n;

  sld_if #(.payload_t(angle_item_t)) in_ch (.clk(clk));
  sld_if #(.payload_t(deflection_t)) out_ch (.clk(clk));
  sld_if #(.payload_t(reg_write_t)) cfg_ch (.clk(clk));

  deflection_board board;
  int idle_cycles;
  int items_sent;
  int phases_run;
  bit timed_out;

  suspension_linkage_deflection #(.CORDIC_STEPS(Steps)) u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_ch.valid),
    .in_ready             (in_ch.ready),
    .in_cmd               (in_ch.data.cmd),
    .in_arm_angle         (in_ch.data.arm_angle),
    .in_link_angle        (in_ch.data.link_angle),
    .in_interval_ms       (in_ch.data.interval_ms),
    .out_valid            (out_ch.valid),
    .out_ready            (out_ch.ready),
    .out_deflection       (out_ch.data.deflection),
    .out_deflection_speed (out_ch.data.deflection_speed),
    .out_linear_deflection(out_ch.data.linear_deflection),
    .out_linear_speed     (out_ch.data.linear_speed),
    .out_zero_interval    (out_ch.data.zero_interval),
    .cfg_valid            (cfg_ch.valid),
    .cfg_ready            (cfg_ch.ready),
    .cfg_index            (cfg_ch.data.index),
    .cfg_data             (cfg_ch.data.data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every input of the block starts from a known value.
  initial begin
    board = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    idle_cycles = 0;
    items_sent = 0;
    phases_run = 0;
    timed_out = 0;
  end

  // Monitor: items are noted and results checked on the edge at which they are taken.
  // Signals are read before the block's own updates of that edge take effect.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) board.note_input(in_ch.data);
      if (out_ch.valid && out_ch.ready) board.check_result(out_ch.data);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: a long stretch with no handshake on any channel means the block has hung.
  always @(posedge clk) begin
    if (idle_cycles >= WatchdogLimit && !timed_out) begin
      timed_out = 1;
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // The result side stalls for a random number of cycles before taking each result.
  initial begin : result_sink
    int stall;
    @(posedge clk iff rst_n);
    forever begin
      stall = $urandom_range(0, 8);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // Sends a list of items with a random gap before each. Valid is only lowered when a gap
  // follows, so back-to-back items keep it high.
  task automatic send_items(ref angle_item_t items[$]);
    int gap;
    foreach (items[k]) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_ch.valid <= 1'b1;
      in_ch.data <= items[k];
      do @(posedge clk); while (!in_ch.ready);
      items_sent++;
    end
    in_ch.valid <= 1'b0;
  endtask

  // Configuration is only changed once every owed result is back and the block has settled.
  task automatic wait_idle();
    while (board.owed.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_regs(logic [CoordW-1:0] vals[7], bit poke_unused);
    for (int i = 0; i <= RegLink; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.data <= '{index: i[2:0], data: vals[i]};
      do @(posedge clk); while (!cfg_ch.ready);
      board.write_reg(i[2:0], vals[i]);
    end
    // An index past the last register must leave every setting alone.
    if (poke_unused) begin
      cfg_ch.data <= '{index: 3'd7, data: CoordW'($urandom)};
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    phases_run++;
  endtask

  function automatic angle_item_t make_item(bit c, int arm, int link, int intv);
    angle_item_t it;
    it.cmd = c;
    it.arm_angle = arm[AngW-1:0];
    it.link_angle = link[AngW-1:0];
    it.interval_ms = intv[IntvW-1:0];
    return it;
  endfunction

  // Mostly plausible sensor traffic: a capture now and then, small angle steps and short
  // intervals, with a share of wild angles, zero and very long intervals.
  function automatic angle_item_t random_item(ref int arm, ref int link);
    angle_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      arm = $signed(16'($urandom));
      link = $signed(16'($urandom));
    end else begin
      arm = arm + $urandom_range(0, 400) - 200;
      link = link + $urandom_range(0, 400) - 200;
    end
    it = make_item($urandom_range(0, 9) != 0, arm, link, 0);
    arm = it.arm_angle;
    link = it.link_angle;
    pick = $urandom_range(0, 99);
    if (pick < 8) it.interval_ms = '0;
    else if (pick < 25) it.interval_ms = IntvW'($urandom);
    else it.interval_ms = IntvW'($urandom_range(1, 40));
    return it;
  endfunction

  initial begin : stimulus
    angle_item_t items[$];
    logic [CoordW-1:0] vals[7];
    int arm, link;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under reset settings: capture at rest, then updates at the angle and
    // interval extremes, a zero interval, whole-turn wrapping and a second capture.
    items = '{};
    items.push_back(make_item(0, 0, 0, 0));
    items.push_back(make_item(1, 0, 0, 10));
    items.push_back(make_item(1, 32767, 0, 1));
    items.push_back(make_item(1, -32768, 0, 65535));
    items.push_back(make_item(1, 0, 32767, 0));
    items.push_back(make_item(1, 0, -32768, 5));
    items.push_back(make_item(1, 12868, -12868, 1));
    items.push_back(make_item(0, 6434, 6434, 65535));
    items.push_back(make_item(1, -6434, 6434, 1));
    send_items(items);
    wait_idle();

    // Long link and the reset geometry: the linear deflection and its speed come alive.
    vals = '{19'sd145532, 19'sd31960, -19'sd88022, 19'sd139206, -19'sd97109, 19'sd143379,
             19'd262143};
    write_regs(vals, 1);
    items = '{};
    items.push_back(make_item(1, 0, 0, 1));
    items.push_back(make_item(1, 0, 32767, 1));
    items.push_back(make_item(1, 0, 12868, 0));
    items.push_back(make_item(1, 0, -32768, 65535));
    items.push_back(make_item(1, 0, 0, 1));
    items.push_back(make_item(0, 100, 200, 3));
    items.push_back(make_item(1, 300, -200, 2));
    send_items(items);
    wait_idle();

    // Random phases: reset geometry, both extremes and random geometries. The extreme
    // geometries drive the length into saturation.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: vals = '{19'sd145532, 19'sd31960, -19'sd88022, 19'sd139206, -19'sd97109,
                    19'sd143379, 19'd60000};
        1: vals = '{19'h3FFFF, 19'h3FFFF, 19'h40000, 19'h40000, 19'h3FFFF, 19'h3FFFF,
                    19'h3FFFF};
        2: vals = '{19'h40000, 19'h40000, 19'h3FFFF, 19'h3FFFF, 19'h40000, 19'h40000,
                    19'h0};
        default: foreach (vals[i]) vals[i] = CoordW'($urandom);
      endcase
      write_regs(vals, ph == 3);
      arm = 0;
      link = 0;
      items = '{};
      items.push_back(make_item(0, 0, 0, 1));
      repeat (RandomPerPhase) items.push_back(random_item(arm, link));
      send_items(items);
      wait_idle();
    end

    $display("sent %0d items over %0d register settings, %0d results checked",
             items_sent, phases_run + 1, board.checked);
    $display("covered captures, updates, zero intervals and length saturation");
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results still owed", board.errors, board.owed.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
